// ----- rtl/cbd_pkg.sv -----
`timescale 1ns / 1ps
// cbd_pkg: types and constants shared by the column byte to double converter
// no dependencies
package cbd_pkg;

   localparam int MAX_COLUMNS_DEF = 32;
   localparam int COL_W           = 5;
   localparam int CNT_W           = 6;

   typedef enum logic [1:0] {
      CSR_INTEGER_MODE = 2'd0,
      CSR_BIG_ENDIAN   = 2'd1,
      CSR_COLUMN_COUNT = 2'd2,
      CSR_WIDTH_CODES  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_INT    = 2'd0,
      KIND_SINGLE = 2'd1,
      KIND_DOUBLE = 2'd2,
      KIND_ZERO   = 2'd3
   } kind_type;

   localparam logic OP_DATA    = 1'b0;
   localparam logic OP_DISCARD = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [63:0]      value_bits;
      logic [COL_W-1:0] column_index;
      logic             last_of_row;
      logic             width_error;
   } rsp_type;

   typedef struct packed {
      logic [63:0]      raw;
      kind_type         kind;
      logic [COL_W-1:0] column;
      logic             last;
      logic             err;
   } job_type;

endpackage

// ----- rtl/cbd_ram.sv -----
`timescale 1ns / 1ps
// cbd_ram: generic single write port ram with registered read
// no dependencies
module cbd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/cbd_queue.sv -----
`timescale 1ns / 1ps
// cbd_queue: two entry job queue between front and back
// depends on cbd_pkg
module cbd_queue
   import cbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head
);
   job_type    slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= push_job;
      end
   end

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = slot_ff[rp_ff];
endmodule

// ----- rtl/cbd_front.sv -----
`timescale 1ns / 1ps
// cbd_front: byte intake, column assembly and classification into jobs
// depends on cbd_pkg
module cbd_front
   import cbd_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  req_type          item,
   input  logic             integer_mode,
   input  logic             big_endian,
   input  logic [CNT_W-1:0] column_count,
   input  logic [63:0]      width_codes,
   output logic             push,
   output job_type          push_job
);
   logic [63:0]      asm_ff, asm_in;
   logic [2:0]       bic_ff, bic_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             err_ff, err_in;

   logic [CNT_W-1:0] count;
   logic             restart, done, last, bad;
   logic [COL_W-1:0] col;
   logic [63:0]      base, asm_new, raw;
   logic [2:0]       bic;
   logic [1:0]       code;
   kind_type         kind;

   always_comb begin
      if (column_count == '0) begin
         count = CNT_W'(1);
      end else if (column_count > CNT_W'(MAX_COLUMNS)) begin
         count = CNT_W'(MAX_COLUMNS);
      end else begin
         count = column_count;
      end
      restart = ({1'b0, col_ff} >= count);
      col     = restart ? '0 : col_ff;
      bic     = restart ? 3'd0 : bic_ff;
      base    = restart ? 64'd0 : asm_ff;
      if (big_endian) begin
         asm_new = {base[55:0], item.data_byte};
      end else begin
         asm_new = base | ({56'd0, item.data_byte} << {bic, 3'b000});
      end
      code = width_codes[{col, 1'b0} +: 2];
      case (code)
         2'd0:    done = 1'b1;
         2'd1:    done = (bic >= 3'd1);
         2'd2:    done = (bic >= 3'd3);
         default: done = (bic >= 3'd7);
      endcase
      case (code)
         2'd0:    raw = {56'd0, asm_new[7:0]};
         2'd1:    raw = {48'd0, asm_new[15:0]};
         2'd2:    raw = {32'd0, asm_new[31:0]};
         default: raw = asm_new;
      endcase
      bad = 1'b0;
      if (integer_mode) begin
         kind = KIND_INT;
      end else if (code == 2'd2) begin
         kind = KIND_SINGLE;
      end else if (code == 2'd3) begin
         kind = KIND_DOUBLE;
      end else begin
         kind = KIND_ZERO;
         bad  = 1'b1;
      end
      last = ({1'b0, col} + CNT_W'(1) >= count);

      asm_in = asm_ff;
      bic_in = bic_ff;
      col_in = col_ff;
      err_in = err_ff;
      push   = 1'b0;
      if (take && item.op == OP_DISCARD) begin
         asm_in = '0;
         bic_in = '0;
         col_in = '0;
         err_in = 1'b0;
      end else if (take) begin
         if (!done) begin
            asm_in = asm_new;
            bic_in = bic + 3'd1;
            col_in = col;
         end else begin
            push   = 1'b1;
            asm_in = '0;
            bic_in = '0;
            err_in = err_ff | bad;
            col_in = last ? '0 : col + COL_W'(1);
         end
      end
      push_job.raw    = raw;
      push_job.kind   = kind;
      push_job.column = col;
      push_job.last   = last;
      push_job.err    = err_ff | bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_ff <= '0;
         bic_ff <= '0;
         col_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         asm_ff <= asm_in;
         bic_ff <= bic_in;
         col_ff <= col_in;
         err_ff <= err_in;
      end
   end
endmodule

// ----- rtl/cbd_back.sv -----
`timescale 1ns / 1ps
// cbd_back: conversion to double, row store and row emission
// depends on cbd_pkg and cbd_ram
module cbd_back
   import cbd_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);
   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_NORM  = 6'b000010,
      ST_WRITE = 6'b000100,
      ST_RD    = 6'b001000,
      ST_LD    = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [63:0]      norm_ff, norm_in, res_ff, res_in;
   logic [5:0]       sh_ff, sh_in;
   logic [11:0]      ebase_ff, ebase_in;
   logic             sign_ff, sign_in;
   logic [COL_W-1:0] col_ff, col_in, idx_ff, idx_in;
   logic             last_ff, last_in, err_ff, err_in;
   rsp_type          out_ff, out_in;

   logic [63:0] rdata;
   logic        se, sf;
   logic [7:0]  s_e;
   logic [22:0] s_f;
   logic [53:0] mant;
   logic        round_up;
   logic [11:0] ex;

   cbd_ram #(.WIDTH(64), .DEPTH(MAX_COLUMNS), .AW(AW)) u_row_store (
      .clock (clock),
      .we    (state_ff == ST_WRITE),
      .waddr (col_ff[AW-1:0]),
      .wdata (res_ff),
      .raddr (idx_ff[AW-1:0]),
      .rdata (rdata)
   );

   always_comb begin
      se       = job.raw[31];
      s_e      = job.raw[30:23];
      s_f      = job.raw[22:0];
      sf       = (s_f != '0);
      round_up = norm_ff[10] & ((|norm_ff[9:0]) | norm_ff[11]);
      mant     = {1'b0, norm_ff[63:11]} + {53'd0, round_up};
      ex       = ebase_ff - {6'd0, sh_ff} + {11'd0, mant[53]};

      state_in = state_ff;
      norm_in  = norm_ff;
      res_in   = res_ff;
      sh_in    = sh_ff;
      ebase_in = ebase_ff;
      sign_in  = sign_ff;
      col_in   = col_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      out_in   = out_ff;
      job_pop  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               col_in   = job.column;
               last_in  = job.last;
               err_in   = job.err;
               norm_in  = job.raw;
               sh_in    = '0;
               sign_in  = 1'b0;
               ebase_in = 12'd1086;
               state_in = ST_WRITE;
               case (job.kind)
                  KIND_INT: begin
                     res_in = '0;
                     if (job.raw != '0) begin
                        state_in = ST_NORM;
                     end
                  end
                  KIND_SINGLE: begin
                     if (s_e == 8'hFF) begin
                        res_in = {se, 11'h7FF, (sf ? {1'b1, s_f[21:0]} : 23'd0), 29'd0};
                     end else if (s_e == 8'd0) begin
                        res_in   = {se, 63'd0};
                        norm_in  = {41'd0, s_f};
                        sign_in  = se;
                        ebase_in = 12'd937;
                        if (sf) begin
                           state_in = ST_NORM;
                        end
                     end else begin
                        res_in = {se, 3'd0, s_e + 8'd128, s_f, 29'd0};
                        if (s_e[7]) begin
                           res_in[62:52] = {3'b100, s_e - 8'd128};
                        end else begin
                           res_in[62:52] = {3'b011, s_e + 8'd128};
                        end
                     end
                  end
                  KIND_DOUBLE: res_in = job.raw;
                  default:     res_in = '0;
               endcase
            end
         end
         ST_NORM: begin
            if (norm_ff[63]) begin
               res_in   = {sign_ff, ex[10:0], (mant[53] ? 52'd0 : mant[51:0])};
               state_in = ST_WRITE;
            end else if (norm_ff[63:56] == 8'd0) begin
               norm_in = norm_ff << 8;
               sh_in   = sh_ff + 6'd8;
            end else begin
               norm_in = norm_ff << 1;
               sh_in   = sh_ff + 6'd1;
            end
         end
         ST_WRITE: begin
            idx_in   = '0;
            state_in = last_ff ? ST_RD : ST_IDLE;
         end
         ST_RD: state_in = ST_LD;
         ST_LD: begin
            out_in.value_bits   = rdata;
            out_in.column_index = idx_ff;
            out_in.last_of_row  = (idx_ff == col_ff);
            out_in.width_error  = err_ff;
            state_in            = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (idx_ff == col_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + COL_W'(1);
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      norm_ff  <= norm_in;
      res_ff   <= res_in;
      sh_ff    <= sh_in;
      ebase_ff <= ebase_in;
      sign_ff  <= sign_in;
      col_ff   <= col_in;
      idx_ff   <= idx_in;
      last_ff  <= last_in;
      err_ff   <= err_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_item  = out_ff;

   a_idx_in_row : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.column_index <= col_ff))
      else $error("emitted column beyond end of row");

   a_norm_leaves : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NORM && norm_ff[63]) |=> (state_ff == ST_WRITE))
      else $error("normalization did not finish");

   a_row_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_item.last_of_row) |=> (state_ff == ST_IDLE))
      else $error("row emission did not end at last column");

   a_no_pop_busy : assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (state_ff == ST_IDLE && job_valid))
      else $error("job taken while busy");
endmodule

// ----- rtl/column_bytes_to_double_converter.sv -----
`timescale 1ns / 1ps
// column_bytes_to_double_converter: top level, csr block, front, queue and back
// depends on cbd_pkg, cbd_front, cbd_queue, cbd_back
//
//   port group   direction  handshake            payload
//   req_         in         req_valid/req_ready  req_type (op, data_byte)
//   rsp_         out        rsp_valid/rsp_ready  rsp_type (value, column, last, error)
//   csr_         in         csr_we               csr_index, csr_wdata
//
// a byte item is taken whenever the two entry queue has room
// each column passes the back unit idle and write states, plus the normalize shifter when needed
// each emitted column passes the read, load and output states, paced by the registered row store read
// reset is synchronous; the row store holds no reset value
// a stalled rsp_ready holds the back unit; the front keeps taking bytes until the queue fills
module column_bytes_to_double_converter
   import cbd_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_item,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [63:0]   csr_wdata
);
   logic             int_mode_ff, big_end_ff;
   logic [CNT_W-1:0] count_ff;
   logic [63:0]      codes_ff;
   logic             full, push, not_empty, pop;
   job_type          push_job, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         int_mode_ff <= 1'b1;
         big_end_ff  <= 1'b1;
         count_ff    <= CNT_W'(1);
         codes_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INTEGER_MODE: int_mode_ff <= csr_wdata[0];
            CSR_BIG_ENDIAN:   big_end_ff  <= csr_wdata[0];
            CSR_COLUMN_COUNT: count_ff    <= csr_wdata[CNT_W-1:0];
            CSR_WIDTH_CODES:  codes_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = !full;

   cbd_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (req_valid && req_ready),
      .item         (req_item),
      .integer_mode (int_mode_ff),
      .big_endian   (big_end_ff),
      .column_count (count_ff),
      .width_codes  (codes_ff),
      .push         (push),
      .push_job     (push_job)
   );

   cbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   cbd_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (not_empty),
      .job       (head),
      .job_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );
endmodule
